// File: hw/rtl/hrtc_pkg.sv
// Shared types and constants for the HTTP request target checker.
package hrtc_pkg;

   localparam int PhaseWidth = 3;
   localparam int FormWidth  = 2;

   localparam logic [PhaseWidth-1:0] PH_START  = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_SCHEME = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_COLON  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_SLASH  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_HOST   = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_PATH   = 3'd5;

   localparam logic [FormWidth-1:0] FORM_PATH      = 2'd0;
   localparam logic [FormWidth-1:0] FORM_ABSOLUTE  = 2'd1;
   localparam logic [FormWidth-1:0] FORM_AUTHORITY = 2'd2;
   localparam logic [FormWidth-1:0] FORM_EMPTY     = 2'd3;

   localparam logic [7:0] CHR_TAB       = 8'd9;
   localparam logic [7:0] CHR_FORM_FEED = 8'd12;
   localparam logic [7:0] CHR_SLASH     = 8'h2f;
   localparam logic [7:0] CHR_STAR      = 8'h2a;
   localparam logic [7:0] CHR_COLON     = 8'h3a;
   localparam logic [7:0] CHR_AT        = 8'h40;
   localparam logic [7:0] CHR_QMARK     = 8'h3f;

   typedef struct packed {
      logic is_alpha;
      logic is_scheme;
      logic is_host;
      logic is_path;
      logic is_slash;
      logic is_star;
      logic is_colon;
      logic is_at;
      logic is_qmark;
   } byte_class_type;

endpackage

// File: hw/rtl/http_request_target_check.sv
// HTTP request target checker top level.
// Takes one target byte per req transaction and returns one verdict (ok flag and
// target form) on the transaction that ends the target, either a final byte or an
// empty mark. The byte is classified and the phase state updated in the cycle it
// is accepted, and the verdict appears in the rsp register on the next cycle. A
// new byte is accepted every cycle as long as the rsp register is empty or being
// drained; only a pending unread verdict stalls the input.
module http_request_target_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_connect_request,
   input  logic       req_final_item,
   input  logic       req_empty_target,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_target_ok,
   output logic [1:0] rsp_target_form
);

   hrtc_pkg::byte_class_type byte_class;

   logic [hrtc_pkg::PhaseWidth-1:0] phase_ff, phase_in, phase_next;
   logic [hrtc_pkg::FormWidth-1:0]  form_ff, form_in, form_next;
   logic                            prev_at_ff, prev_at_in, prev_at_next;
   logic                            bad_ff, bad_in, bad_next;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [hrtc_pkg::FormWidth-1:0]  rsp_form_ff, rsp_form_in;
   logic                            req_fire;
   logic                            ends_target;

   hrtc_classify u_classify (
      .data_byte  (req_data_byte),
      .byte_class (byte_class)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign ends_target = req_final_item || req_empty_target;

   // state after taking the byte
   always_comb begin
      phase_next   = phase_ff;
      form_next    = form_ff;
      prev_at_next = prev_at_ff;
      bad_next     = bad_ff;
      if (!req_empty_target) begin
         case (phase_ff)
            hrtc_pkg::PH_START: begin
               if (byte_class.is_slash || byte_class.is_star) begin
                  form_next  = hrtc_pkg::FORM_PATH;
                  phase_next = hrtc_pkg::PH_PATH;
               end else if (req_connect_request) begin
                  form_next = hrtc_pkg::FORM_AUTHORITY;
                  if (byte_class.is_qmark) begin
                     phase_next = hrtc_pkg::PH_PATH;
                  end else begin
                     phase_next   = hrtc_pkg::PH_HOST;
                     bad_next     = bad_ff || !byte_class.is_host;
                     prev_at_next = byte_class.is_at;
                  end
               end else begin
                  form_next  = hrtc_pkg::FORM_ABSOLUTE;
                  phase_next = hrtc_pkg::PH_SCHEME;
                  bad_next   = bad_ff || !byte_class.is_alpha;
               end
            end
            hrtc_pkg::PH_SCHEME: begin
               if (byte_class.is_colon) begin
                  phase_next = hrtc_pkg::PH_COLON;
               end else begin
                  bad_next = bad_ff || !byte_class.is_scheme;
               end
            end
            hrtc_pkg::PH_COLON: begin
               if (byte_class.is_slash) begin
                  phase_next = hrtc_pkg::PH_SLASH;
               end else begin
                  bad_next = 1'b1;
               end
            end
            hrtc_pkg::PH_SLASH: begin
               if (byte_class.is_slash) begin
                  phase_next = hrtc_pkg::PH_HOST;
               end else begin
                  bad_next = 1'b1;
               end
            end
            hrtc_pkg::PH_HOST: begin
               if (byte_class.is_slash || byte_class.is_qmark) begin
                  phase_next = hrtc_pkg::PH_PATH;
               end else begin
                  bad_next     = bad_ff || !byte_class.is_host ||
                                 (byte_class.is_at && prev_at_ff);
                  prev_at_next = byte_class.is_at;
               end
            end
            default: begin
               bad_next = bad_ff || !byte_class.is_path;
            end
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      form_in      = form_ff;
      prev_at_in   = prev_at_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_form_in  = rsp_form_ff;
      if (req_fire) begin
         if (ends_target) begin
            phase_in     = hrtc_pkg::PH_START;
            form_in      = hrtc_pkg::FORM_PATH;
            prev_at_in   = 1'b0;
            bad_in       = 1'b0;
            rsp_valid_in = 1'b1;
            if (phase_next == hrtc_pkg::PH_START) begin
               rsp_ok_in   = 1'b0;
               rsp_form_in = hrtc_pkg::FORM_EMPTY;
            end else begin
               rsp_ok_in   = !bad_next && ((phase_next == hrtc_pkg::PH_HOST) ||
                                           (phase_next == hrtc_pkg::PH_PATH));
               rsp_form_in = form_next;
            end
         end else begin
            phase_in   = phase_next;
            form_in    = form_next;
            prev_at_in = prev_at_next;
            bad_in     = bad_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hrtc_pkg::PH_START;
         form_ff      <= hrtc_pkg::FORM_PATH;
         prev_at_ff   <= 1'b0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         form_ff      <= form_in;
         prev_at_ff   <= prev_at_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_form_ff <= rsp_form_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_target_ok   = rsp_ok_ff;
   assign rsp_target_form = rsp_form_ff;

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ends_target) |=> (phase_ff == hrtc_pkg::PH_START) && !bad_ff)
      else $error("target state not cleared after ending transaction");

   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && ends_target))
      else $error("verdict without an ending transaction");

   a_empty_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_form_ff == hrtc_pkg::FORM_EMPTY)) |-> !rsp_ok_ff)
      else $error("empty target reported ok");

   a_at_only_after_host: assert property (@(posedge clock) disable iff (reset)
      prev_at_ff |-> ((phase_ff == hrtc_pkg::PH_HOST) || (phase_ff == hrtc_pkg::PH_PATH)))
      else $error("at-sign tracking outside host or path part");

   a_authority_phase: assert property (@(posedge clock) disable iff (reset)
      (form_ff == hrtc_pkg::FORM_AUTHORITY) |->
         ((phase_ff == hrtc_pkg::PH_HOST) || (phase_ff == hrtc_pkg::PH_PATH)))
      else $error("authority form outside host or path phase");

endmodule

// File: hw/rtl/hrtc_classify.sv
// Character class decoder for one request target byte.
module hrtc_classify (
   input  logic [7:0]              data_byte,
   output hrtc_pkg::byte_class_type byte_class
);

   logic is_alpha;
   logic is_digit;
   logic host_punct;

   assign is_alpha = ((data_byte >= 8'd65) && (data_byte <= 8'd90)) ||
                     ((data_byte >= 8'd97) && (data_byte <= 8'd122));
   assign is_digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);

   always_comb begin
      case (data_byte)
         8'h21, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
         8'h2d, 8'h2e, 8'h3a, 8'h3b, 8'h3d, 8'h40, 8'h5b, 8'h5d, 8'h5f,
         8'h7e: begin
            host_punct = 1'b1;
         end
         default: begin
            host_punct = 1'b0;
         end
      endcase
   end

   always_comb begin
      byte_class.is_alpha  = is_alpha;
      byte_class.is_scheme = is_alpha || is_digit || (data_byte == 8'h2b) ||
                             (data_byte == 8'h2d) || (data_byte == 8'h2e);
      byte_class.is_host   = is_alpha || is_digit || host_punct;
      byte_class.is_path   = (data_byte == hrtc_pkg::CHR_TAB) ||
                             (data_byte == hrtc_pkg::CHR_FORM_FEED) ||
                             ((data_byte >= 8'd33) && (data_byte <= 8'd126));
      byte_class.is_slash  = (data_byte == hrtc_pkg::CHR_SLASH);
      byte_class.is_star   = (data_byte == hrtc_pkg::CHR_STAR);
      byte_class.is_colon  = (data_byte == hrtc_pkg::CHR_COLON);
      byte_class.is_at     = (data_byte == hrtc_pkg::CHR_AT);
      byte_class.is_qmark  = (data_byte == hrtc_pkg::CHR_QMARK);
   end

endmodule
